// File: hdl/text_word_wrap_justifier_macros.svh
// Assertion macros for the text word wrap justifier checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TEXT_WORD_WRAP_JUSTIFIER_MACROS_SVH
`define TEXT_WORD_WRAP_JUSTIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TWW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TWW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tww_pkg.sv
// Shared constants and controller/datapath interface types for the justifier.
// No dependencies.
package tww_pkg;

  localparam int LINE_CAPACITY_DEF = 60;
  localparam int WORD_CAPACITY_DEF = 20;
  localparam logic [5:0] LINE_WIDTH_RST = 6'd60;
  localparam int WOL_W = 5;
  localparam logic [WOL_W-1:0] WOL_MAX = 5'd31;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] EMIT_CHAR  = 2'd0;
  localparam logic [1:0] EMIT_SPACE = 2'd1;
  localparam logic [1:0] EMIT_NL    = 2'd2;

  typedef struct packed {
    logic       word_wr;
    logic       idx_clr;
    logic       just_init;
    logic       line_rd;
    logic       idx_inc;
    logic       div_start;
    logic       sp_load;
    logic       sp_dec;
    logic       gap_done;
    logic       nl_done;
    logic       sep_wr;
    logic       cp_init;
    logic       word_rd;
    logic       cp_wr;
    logic       word_fin;
    logic       clr_all;
    logic       emit;
    logic [1:0] emit_sel;
    logic       fin;
  } tww_cmd_t;

  typedef struct packed {
    logic word_empty;
    logic no_fit;
    logic idx_end;
    logic is_space;
    logic div_done;
    logic sp_zero;
    logic cp_end;
    logic can_emit;
    logic fin_ok;
  } tww_stat_t;

endpackage

// File: hdl/tww_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// No package dependencies.
module tww_div #(
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;

  assign shifted = {rem_r[DW-1:0], quo_r[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = diff[DW+1] ? shifted : diff[DW:0];
      quo_nxt = {quo_r[DW-2:0], ~diff[DW+1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/tww_dp.sv
// Justifier datapath: word and line buffers, line counters, gap divider,
// byte packer and output register. Uses tww_pkg and tww_div.
module tww_dp #(
  parameter int LINE_CAPACITY = tww_pkg::LINE_CAPACITY_DEF,
  parameter int WORD_CAPACITY = tww_pkg::WORD_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tww_pkg::tww_cmd_t cmd,
  output tww_pkg::tww_stat_t stat,
  input  logic [7:0]        char_in,
  input  logic              cfg_wr_en,
  input  logic [5:0]        cfg_line_width,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_first_byte,
  output logic [7:0]        out_second_byte,
  output logic [1:0]        out_byte_count,
  output logic              out_last_result
);

  localparam int LLW = $clog2(LINE_CAPACITY + 1);
  localparam int LIW = $clog2(LINE_CAPACITY);
  localparam int WLW = $clog2(WORD_CAPACITY + 1);
  localparam int WIW = (WORD_CAPACITY > 1) ? $clog2(WORD_CAPACITY) : 1;
  localparam int WOW = tww_pkg::WOL_W;

  logic [7:0] line_mem [LINE_CAPACITY];
  logic [7:0] word_mem [WORD_CAPACITY];

  logic [5:0]     lw_r;
  logic [LLW-1:0] ll_r, idx_r, extra_r, q_r, sp_r;
  logic [WOW-1:0] wol_r, gaps_r;
  logic [WLW-1:0] wl_r, j_r;
  logic           odd_r;
  logic [7:0]     line_q_r, word_q_r;

  logic [1:0]     pcnt_r;
  logic [7:0]     p0_r, p1_r;
  logic           ov_r;
  logic [7:0]     of_r, os_r;
  logic [1:0]     oc_r;
  logic           ol_r;

  logic [LLW-1:0] eff_w, room, qsel, qm, div_q;
  logic [LLW:0]   need;
  logic           div_done, m_bit, out_free, ll_room;
  logic [7:0]     emit_byte;

  assign eff_w = (lw_r > 6'(LINE_CAPACITY)) ? LLW'(LINE_CAPACITY) : lw_r[LLW-1:0];
  assign room  = (eff_w > ll_r) ? (eff_w - ll_r) : '0;
  assign need  = (LLW+1)'(wl_r) + (LLW+1)'(1);
  assign ll_room = ll_r < LLW'(LINE_CAPACITY);

  tww_div #(.DW(LLW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (extra_r),
    .divisor  (LLW'(gaps_r)),
    .done     (div_done),
    .quotient (div_q)
  );

  // odd lines give every gap at least one extra space while any remain
  assign m_bit = odd_r && (extra_r != '0);
  assign qsel  = (gaps_r == '0) ? extra_r : div_q;
  assign qm    = (qsel == '0 && m_bit) ? LLW'(1) : qsel;

  assign out_free = !ov_r || !out_stall;

  always_comb begin
    case (cmd.emit_sel)
      tww_pkg::EMIT_CHAR:  emit_byte = line_q_r;
      tww_pkg::EMIT_SPACE: emit_byte = tww_pkg::CH_SPACE;
      tww_pkg::EMIT_NL:    emit_byte = tww_pkg::CH_NL;
      default:             emit_byte = tww_pkg::CH_NL;
    endcase
  end

  assign stat.word_empty = (wl_r == '0);
  assign stat.no_fit     = need > {1'b0, room};
  assign stat.idx_end    = idx_r >= ll_r;
  assign stat.is_space   = (line_q_r == tww_pkg::CH_SPACE);
  assign stat.div_done   = div_done;
  assign stat.sp_zero    = (sp_r == '0);
  assign stat.cp_end     = j_r >= wl_r;
  assign stat.can_emit   = (pcnt_r != 2'd2) || out_free;
  assign stat.fin_ok     = (pcnt_r == 2'd0) || out_free;

  // buffers
  always_ff @(posedge clk) begin
    if (cmd.word_wr) begin
      if (wl_r < WLW'(WORD_CAPACITY)) begin
        word_mem[wl_r[WIW-1:0]] <= char_in;
      end else begin
        word_mem[WIW'(WORD_CAPACITY - 1)] <= tww_pkg::CH_STAR;
      end
    end
    if (cmd.word_rd) begin
      word_q_r <= word_mem[j_r[WIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sep_wr && wol_r != '0 && ll_room) begin
      line_mem[ll_r[LIW-1:0]] <= tww_pkg::CH_SPACE;
    end else if (cmd.cp_wr && ll_room) begin
      line_mem[ll_r[LIW-1:0]] <= word_q_r;
    end
    if (cmd.line_rd) begin
      line_q_r <= line_mem[idx_r[LIW-1:0]];
    end
  end

  // line state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r  <= tww_pkg::LINE_WIDTH_RST;
      ll_r  <= '0;
      wol_r <= '0;
      wl_r  <= '0;
      odd_r <= 1'b0;
      idx_r <= '0;
      j_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        lw_r <= cfg_line_width;
      end
      if (cmd.word_wr && wl_r < WLW'(WORD_CAPACITY)) begin
        wl_r <= wl_r + WLW'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + LLW'(1);
      end
      if (cmd.nl_done) begin
        ll_r  <= '0;
        wol_r <= '0;
        odd_r <= ~odd_r;
      end
      if ((cmd.sep_wr && wol_r != '0 && ll_room) || (cmd.cp_wr && ll_room)) begin
        ll_r <= ll_r + LLW'(1);
      end
      if (cmd.cp_init) begin
        j_r <= '0;
      end else if (cmd.cp_wr) begin
        j_r <= j_r + WLW'(1);
      end
      if (cmd.word_fin) begin
        if (wol_r != tww_pkg::WOL_MAX) begin
          wol_r <= wol_r + WOW'(1);
        end
        wl_r <= '0;
      end
      if (cmd.clr_all) begin
        ll_r  <= '0;
        wol_r <= '0;
        wl_r  <= '0;
        odd_r <= 1'b0;
      end
    end
  end

  // gap padding
  always_ff @(posedge clk) begin
    if (cmd.just_init) begin
      extra_r <= room;
      gaps_r  <= (wol_r != '0) ? (wol_r - WOW'(1)) : '0;
    end else if (cmd.gap_done) begin
      extra_r <= extra_r - q_r;
      if (gaps_r != '0) begin
        gaps_r <= gaps_r - WOW'(1);
      end
    end
    if (cmd.sp_load) begin
      q_r  <= qm;
      sp_r <= qm;
    end else if (cmd.sp_dec) begin
      sp_r <= sp_r - LLW'(1);
    end
  end

  // byte packer: a pair is held back until the next byte shows it is not last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (cmd.emit) begin
        if (pcnt_r == 2'd2) begin
          ov_r   <= 1'b1;
          of_r   <= p0_r;
          os_r   <= p1_r;
          oc_r   <= 2'd2;
          ol_r   <= 1'b0;
          p0_r   <= emit_byte;
          pcnt_r <= 2'd1;
        end else if (pcnt_r == 2'd1) begin
          p1_r   <= emit_byte;
          pcnt_r <= 2'd2;
        end else begin
          p0_r   <= emit_byte;
          pcnt_r <= 2'd1;
        end
      end else if (cmd.fin && pcnt_r != 2'd0) begin
        ov_r   <= 1'b1;
        of_r   <= p0_r;
        os_r   <= (pcnt_r == 2'd2) ? p1_r : 8'd0;
        oc_r   <= pcnt_r;
        ol_r   <= 1'b1;
        pcnt_r <= 2'd0;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_first_byte  = of_r;
  assign out_second_byte = os_r;
  assign out_byte_count  = oc_r;
  assign out_last_result = ol_r;

endmodule

// File: hdl/tww_ctrl.sv
// Justifier controller: sequences word finish, justified and plain line
// emission over the datapath. Uses tww_pkg.
module tww_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [7:0]         in_char_in,
  output tww_pkg::tww_cmd_t  cmd,
  input  tww_pkg::tww_stat_t stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FW   = 4'd1;
  localparam logic [3:0] S_JRD  = 4'd2;
  localparam logic [3:0] S_JCHK = 4'd3;
  localparam logic [3:0] S_JDIV = 4'd4;
  localparam logic [3:0] S_JSP  = 4'd5;
  localparam logic [3:0] S_JNL  = 4'd6;
  localparam logic [3:0] S_SEP  = 4'd7;
  localparam logic [3:0] S_CRD  = 4'd8;
  localparam logic [3:0] S_CWR  = 4'd9;
  localparam logic [3:0] S_FRD  = 4'd10;
  localparam logic [3:0] S_FEM  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       end_r, end_nxt;
  logic       is_sep;

  assign is_sep = (in_char_in == tww_pkg::CH_SPACE) || (in_char_in == tww_pkg::CH_NL) ||
                  (in_char_in == tww_pkg::CH_TAB);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    end_nxt   = end_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == tww_pkg::CMD_TEXT && !is_sep) begin
            cmd.word_wr = 1'b1;
          end else begin
            end_nxt   = (in_cmd == tww_pkg::CMD_END);
            state_nxt = S_FW;
          end
        end
      end
      S_FW: begin
        if (stat.word_empty) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = end_r ? S_FRD : S_DONE;
        end else if (stat.no_fit) begin
          cmd.idx_clr   = 1'b1;
          cmd.just_init = 1'b1;
          state_nxt     = S_JRD;
        end else begin
          state_nxt = S_SEP;
        end
      end
      S_JRD: begin
        if (stat.idx_end) begin
          state_nxt = S_JNL;
        end else begin
          cmd.line_rd = 1'b1;
          state_nxt   = S_JCHK;
        end
      end
      S_JCHK: begin
        if (!stat.is_space) begin
          if (stat.can_emit) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = tww_pkg::EMIT_CHAR;
            cmd.idx_inc  = 1'b1;
            state_nxt    = S_JRD;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_JDIV;
        end
      end
      S_JDIV: begin
        if (stat.div_done) begin
          cmd.sp_load = 1'b1;
          state_nxt   = S_JSP;
        end
      end
      S_JSP: begin
        if (stat.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = tww_pkg::EMIT_SPACE;
          if (stat.sp_zero) begin
            cmd.gap_done = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_nxt    = S_JRD;
          end else begin
            cmd.sp_dec = 1'b1;
          end
        end
      end
      S_JNL: begin
        if (stat.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = tww_pkg::EMIT_NL;
          cmd.nl_done  = 1'b1;
          state_nxt    = S_SEP;
        end
      end
      S_SEP: begin
        cmd.sep_wr  = 1'b1;
        cmd.cp_init = 1'b1;
        state_nxt   = S_CRD;
      end
      S_CRD: begin
        if (stat.cp_end) begin
          cmd.word_fin = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = end_r ? S_FRD : S_DONE;
        end else begin
          cmd.word_rd = 1'b1;
          state_nxt   = S_CWR;
        end
      end
      S_CWR: begin
        cmd.cp_wr = 1'b1;
        state_nxt = S_CRD;
      end
      S_FRD: begin
        if (stat.idx_end) begin
          cmd.clr_all = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.line_rd = 1'b1;
          state_nxt   = S_FEM;
        end
      end
      S_FEM: begin
        if (stat.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = tww_pkg::EMIT_CHAR;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_FRD;
        end
      end
      S_DONE: begin
        if (stat.fin_ok) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

// File: hdl/text_word_wrap_justifier.sv
// Greedy word wrap with full justification, top level.
// Depends on tww_pkg, tww_ctrl, tww_dp (and tww_div below it).
//
// Usage: text bytes enter on in_* (valid/stall); in_cmd = 1 marks end of text.
// Results leave on out_* carrying one or two bytes each; out_last_result
// flags the final result of an item. Items that cause no output give none.
// line_width is written through cfg_wr_en/cfg_line_width while idle.
// A word byte is stored without stalling the input. A separator finishes
// the pending word, which is copied byte by byte from the word buffer into
// the line buffer, justifying and emitting the line first if the word does
// not fit. Emitting a line walks the line buffer byte by byte, then emits
// the newline; each gap of a justified line runs a divide (one quotient bit
// per cycle) and then emits its spaces. An end item does what a separator
// does and then emits the last line as it stands, with no newline.
// in_stall is high while an item is being worked on.
// Results are packed through a one-pair holding stage into an output
// register; when out_stall is high, emission pauses with nothing lost.
// Reset (rst_n low, synchronous) empties the line and word, clears the
// line parity and sets line_width to 60; buffer contents are not cleared.
module text_word_wrap_justifier #(
  parameter int LINE_CAPACITY = tww_pkg::LINE_CAPACITY_DEF,
  parameter int WORD_CAPACITY = tww_pkg::WORD_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic [1:0] out_byte_count,
  output logic       out_last_result,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_line_width
);

  tww_pkg::tww_cmd_t  cmd;
  tww_pkg::tww_stat_t stat;

  tww_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_char_in (in_char_in),
    .cmd        (cmd),
    .stat       (stat)
  );

  tww_dp #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .WORD_CAPACITY (WORD_CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .char_in         (in_char_in),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_line_width  (cfg_line_width),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_byte_count  (out_byte_count),
    .out_last_result (out_last_result)
  );

endmodule

// File: hdl/tww_checker.sv
// Port-level checker for the justifier, bound to the top level.
// Depends on text_word_wrap_justifier_macros.svh.
`include "text_word_wrap_justifier_macros.svh"

module tww_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_second_byte,
  input logic [1:0] out_byte_count,
  input logic       out_last_result
);

  `TWW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `TWW_ASSERT_IMP(a_cnt_range, out_valid, out_byte_count == 2'd1 || out_byte_count == 2'd2,
                  "bad byte count")
  `TWW_ASSERT_IMP(a_single_last, out_valid && out_byte_count == 2'd1, out_last_result,
                  "single-byte result not final")
  `TWW_ASSERT_IMP(a_single_zero, out_valid && out_byte_count == 2'd1, out_second_byte == 8'd0,
                  "unused byte not zero")
  `TWW_ASSERT_NXT(a_end_busy, in_valid && !in_stall && in_cmd, in_stall,
                  "end item finished without flush")

endmodule

bind text_word_wrap_justifier tww_checker u_tww_checker (.*);

// File: test/tb.sv
// Testbench for text_word_wrap_justifier: greedy wrap with full justification.
// Drives bursts of text and end items with random stalls and checks every result
// against a behavioral predictor. Depends on tww_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

  localparam int LCAP = 60;
  localparam int WCAP = 20;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } text_item_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] cnt;
    logic       last;
  } byte_pair_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_cmd = 1'b0;
  logic [7:0] in_char_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_first_byte;
  logic [7:0] out_second_byte;
  logic [1:0] out_byte_count;
  logic       out_last_result;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_line_width = 6'd60;

  text_word_wrap_justifier uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_char_in(in_char_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_byte(out_first_byte), .out_second_byte(out_second_byte),
    .out_byte_count(out_byte_count), .out_last_result(out_last_result),
    .cfg_wr_en(cfg_wr_en), .cfg_line_width(cfg_line_width)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [7:0] p_line[LCAP];
  logic [7:0] p_word[WCAP];
  int         p_len, p_words, p_wlen, p_odd, p_width;
  logic [7:0] emitted[$];

  text_item_t pending_items[$];
  byte_pair_t expected_pairs[$];
  int         errors = 0;
  bit         hold_long = 1'b0;

  function automatic int room_width();
    return (p_width > LCAP) ? LCAP : p_width;
  endfunction

  function automatic void justify_line();
    int w, extra, gaps, m, q;
    w = room_width();
    extra = (w > p_len) ? w - p_len : 0;
    gaps = (p_words > 0) ? p_words - 1 : 0;
    for (int i = 0; i < p_len; i++) begin
      if (p_line[i] != tww_pkg::CH_SPACE) begin
        emitted.push_back(p_line[i]);
      end else begin
        m = (p_odd != 0 && extra >= 1) ? 1 : 0;
        q = (gaps > 0) ? extra / gaps : extra;
        if (q < m) q = m;
        for (int k = 0; k <= q; k++) emitted.push_back(tww_pkg::CH_SPACE);
        extra -= q;
        if (gaps > 0) gaps--;
      end
    end
    emitted.push_back(tww_pkg::CH_NL);
    p_odd ^= 1;
    p_len = 0;
    p_words = 0;
  endfunction

  function automatic void close_word();
    int w, room;
    w = room_width();
    room = (w > p_len) ? w - p_len : 0;
    if (p_wlen == 0) return;
    if (p_wlen + 1 > room) justify_line();
    if (p_words > 0 && p_len < LCAP) p_line[p_len++] = tww_pkg::CH_SPACE;
    for (int i = 0; i < p_wlen; i++)
      if (p_len < LCAP) p_line[p_len++] = p_word[i];
    if (p_words < 31) p_words++;
    p_wlen = 0;
  endfunction

  function automatic void predict_text(text_item_t it);
    byte_pair_t bp;
    int n;
    emitted.delete();
    if (it.cmd == tww_pkg::CMD_END) begin
      close_word();
      for (int i = 0; i < p_len; i++) emitted.push_back(p_line[i]);
      p_len = 0; p_words = 0; p_wlen = 0; p_odd = 0;
    end else if (it.ch == tww_pkg::CH_SPACE || it.ch == tww_pkg::CH_NL ||
                 it.ch == tww_pkg::CH_TAB) begin
      close_word();
    end else if (p_wlen < WCAP) begin
      p_word[p_wlen++] = it.ch;
    end else begin
      p_word[WCAP-1] = tww_pkg::CH_STAR;
    end
    n = (emitted.size() + 1) / 2;
    for (int i = 0; i < n; i++) begin
      bp.b0 = emitted[2*i];
      bp.b1 = (2*i+1 < emitted.size()) ? emitted[2*i+1] : 8'h00;
      bp.cnt = (2*i+1 < emitted.size()) ? 2'd2 : 2'd1;
      bp.last = (i == n - 1);
      expected_pairs.push_back(bp);
    end
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    text_item_t acc;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        acc.cmd = in_cmd;
        acc.ch = in_char_in;
        predict_text(acc);
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_cmd <= pending_items[0].cmd;
        in_char_in <= pending_items[0].ch;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus one long hold-off
  int stall_phase = 0, hold_cnt = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_long && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else if (stall_phase[9:8] == 2'd0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    byte_pair_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result %h %h %0d %0b", $time, out_first_byte,
                 out_second_byte, out_byte_count, out_last_result);
        errors++;
      end else begin
        e = expected_pairs.pop_front();
        if (e !== {out_first_byte, out_second_byte, out_byte_count, out_last_result}) begin
          $display("%0t: mismatch expected %h %h %0d %0b actual %h %h %0d %0b", $time,
                   e.b0, e.b1, e.cnt, e.last, out_first_byte, out_second_byte,
                   out_byte_count, out_last_result);
          errors++;
        end
      end
    end
  end

  task automatic add_item(logic cmd, logic [7:0] ch);
    text_item_t t;
    t.cmd = cmd;
    t.ch = ch;
    pending_items.push_back(t);
  endtask

  task automatic add_letters(int n);
    for (int i = 0; i < n; i++) add_item(tww_pkg::CMD_TEXT, 8'($urandom_range(33, 126)));
  endtask

  task automatic add_random_text(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_SPACE);
      else if (r < 18) add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_NL);
      else if (r < 20) add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_TAB);
      else if (r < 23) add_item(tww_pkg::CMD_TEXT, 8'($urandom));
      else add_item(tww_pkg::CMD_TEXT, 8'($urandom_range(97, 122)));
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_pairs.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_width(logic [5:0] w);
    cfg_wr_en <= 1'b1;
    cfg_line_width <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_width = w;
    @(posedge clk);
  endtask

  initial begin
    p_len = 0; p_words = 0; p_wlen = 0; p_odd = 0; p_width = 60;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, long word, separators, end
    add_item(tww_pkg::CMD_TEXT, 8'h00); add_item(tww_pkg::CMD_TEXT, 8'hFF);
    add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_TAB);
    add_letters(23);
    add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_NL);
    add_item(tww_pkg::CMD_END, 8'hFF);
    add_item(tww_pkg::CMD_END, 8'h00);
    drain();

    set_width(6'd21);
    repeat (2) begin
      add_letters($urandom_range(3, 6));
      add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_SPACE);
    end
    add_letters(20); add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_SPACE);
    add_letters(4); add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_SPACE);
    add_item(tww_pkg::CMD_END, 8'h00);
    drain();

    // width above capacity, then build a line and shrink width mid-line
    set_width(6'd63);
    add_random_text(20);
    drain();
    set_width(6'd5);
    add_letters(8); add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_SPACE);
    add_letters(3); add_item(tww_pkg::CMD_TEXT, tww_pkg::CH_SPACE);
    add_item(tww_pkg::CMD_END, 8'h00);
    drain();

    // random phases, one with a long receiver hold-off
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_width(6'd21);
        1: set_width(6'($urandom_range(21, 60)));
        default: set_width(6'($urandom_range(0, 63)));
      endcase
      if (ph == 1) hold_long = 1'b1;
      add_random_text(20);
      add_item(tww_pkg::CMD_END, 8'($urandom));
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
